/* rtl/tmf_pkg.sv */
// shared types, constants and helpers for the thruster mixer with stick failsafe
// no dependencies
package tmf_pkg;

  localparam int unsigned StickW = 10;
  localparam int unsigned DevW   = 11;
  localparam int unsigned GainW  = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned PulseW = 12;
  localparam int unsigned ProdW  = 28;
  localparam int unsigned WProdW = 45;
  localparam int unsigned SumW   = 48;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [StickW-1:0] NeutralStick = 10'd500;
  localparam logic [PulseW-1:0] NeutralPulse = 12'd1500;
  localparam logic [PulseW-1:0] MaxPulse     = 12'd3000;
  localparam logic [GainW-1:0]  WeightQ16    = 16'd53084;

  localparam logic [GainW-1:0]  ForwardGainRst = 16'd32768;
  localparam logic [GainW-1:0]  LateralGainRst = 16'd32768;
  localparam logic [GainW-1:0]  YawGainRst     = 16'd9830;
  localparam logic [GainW-1:0]  GasGainRst     = 16'd32768;
  localparam logic [GainW-1:0]  StaleLimitRst  = 16'd250;

  typedef enum logic [1:0] {
    MODE_THROTTLE  = 2'd0,
    MODE_DIRECTION = 2'd1,
    MODE_TICK      = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORWARD_GAIN = 3'd0,
    CFG_LATERAL_GAIN = 3'd1,
    CFG_YAW_GAIN     = 3'd2,
    CFG_GAS_GAIN     = 3'd3,
    CFG_MOTORS_EN    = 3'd4,
    CFG_STALE_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] forward;
    logic [GainW-1:0] lateral;
    logic [GainW-1:0] yaw;
    logic [GainW-1:0] gas;
  } gains_t;

  typedef struct packed {
    logic signed [DevW-1:0] forward;
    logic signed [DevW-1:0] lateral;
    logic signed [DevW-1:0] yaw;
    logic signed [DevW-1:0] gas;
  } dev_t;

  typedef struct packed {
    logic [PulseW-1:0] m1;
    logic [PulseW-1:0] m2;
    logic [PulseW-1:0] m3;
    logic [PulseW-1:0] m4;
    logic [PulseW-1:0] m5;
    logic [PulseW-1:0] m6;
  } pulses_t;

  function automatic logic signed [DevW-1:0] stick_dev(input logic [StickW-1:0] stick);
    stick_dev = $signed({1'b0, NeutralStick}) - $signed({1'b0, stick});
  endfunction

  // drop fraction bits of a q32 sum and keep it within 0..3000
  function automatic logic [PulseW-1:0] to_pulse(input logic signed [SumW-1:0] sum);
    logic [SumW-33:0] whole;
    whole = sum[SumW-1:32];
    if (sum[SumW-1]) begin
      to_pulse = '0;
    end else if (whole > {{(SumW-32-PulseW){1'b0}}, MaxPulse}) begin
      to_pulse = MaxPulse;
    end else begin
      to_pulse = whole[PulseW-1:0];
    end
  endfunction

endpackage

/* rtl/tmf_stick_hold.sv */
// held stick values, arrival stamps and stale-stick timeouts
// depends on tmf_pkg
module tmf_stick_hold (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [1:0]                   mode_i,
  input  logic [tmf_pkg::StickW-1:0]   stick_forward_i,
  input  logic [tmf_pkg::StickW-1:0]   stick_lateral_i,
  input  logic [tmf_pkg::StickW-1:0]   stick_yaw_i,
  input  logic [tmf_pkg::StickW-1:0]   stick_gas_i,
  input  logic [tmf_pkg::TimeW-1:0]    time_now_i,
  input  logic                         auto_yaw_on_i,
  input  logic [tmf_pkg::StickW-1:0]   auto_yaw_value_i,
  input  logic                         auto_depth_on_i,
  input  logic [tmf_pkg::StickW-1:0]   auto_gas_value_i,
  input  logic                         motors_enabled_i,
  input  logic [tmf_pkg::GainW-1:0]    stale_limit_i,
  output logic                         tick_o,
  output tmf_pkg::dev_t                dev_o
);
  import tmf_pkg::*;

  logic [StickW-1:0] fwd_q, fwd_d, lat_q, lat_d, yaw_q, yaw_d, gas_q, gas_d;
  logic [TimeW-1:0]  thr_seen_q, thr_seen_d, dir_seen_q, dir_seen_d;
  logic [TimeW-1:0]  thr_age, dir_age;
  logic              thr_stale, dir_stale;
  logic [StickW-1:0] yaw_src, gas_src;

  assign thr_age   = time_now_i - thr_seen_q;
  assign dir_age   = time_now_i - dir_seen_q;
  assign thr_stale = thr_age >= {{(TimeW-GainW){1'b0}}, stale_limit_i};
  assign dir_stale = dir_age >= {{(TimeW-GainW){1'b0}}, stale_limit_i};

  assign yaw_src = auto_yaw_on_i   ? auto_yaw_value_i : yaw_q;
  assign gas_src = auto_depth_on_i ? auto_gas_value_i : gas_q;

  assign tick_o = mode_i == MODE_TICK;

  // locked motors mix zero deviation, which is neutral on every thruster
  always_comb begin
    if (motors_enabled_i) begin
      dev_o.forward = stick_dev(fwd_q);
      dev_o.lateral = stick_dev(lat_q);
      dev_o.yaw     = stick_dev(yaw_src);
      dev_o.gas     = stick_dev(gas_src);
    end else begin
      dev_o = '0;
    end
  end

  always_comb begin
    fwd_d      = fwd_q;
    lat_d      = lat_q;
    yaw_d      = yaw_q;
    gas_d      = gas_q;
    thr_seen_d = thr_seen_q;
    dir_seen_d = dir_seen_q;
    if (accept_i) begin
      unique case (mode_i)
        MODE_THROTTLE: begin
          gas_d      = stick_gas_i;
          thr_seen_d = time_now_i;
        end
        MODE_DIRECTION: begin
          fwd_d      = stick_forward_i;
          lat_d      = stick_lateral_i;
          yaw_d      = stick_yaw_i;
          dir_seen_d = time_now_i;
        end
        MODE_TICK: begin
          if (motors_enabled_i && thr_stale) begin
            gas_d = NeutralStick;
          end
          if (motors_enabled_i && dir_stale) begin
            fwd_d = NeutralStick;
            lat_d = NeutralStick;
            yaw_d = NeutralStick;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= NeutralStick;
      lat_q      <= NeutralStick;
      yaw_q      <= NeutralStick;
      gas_q      <= NeutralStick;
      thr_seen_q <= '0;
      dir_seen_q <= '0;
    end else begin
      fwd_q      <= fwd_d;
      lat_q      <= lat_d;
      yaw_q      <= yaw_d;
      gas_q      <= gas_d;
      thr_seen_q <= thr_seen_d;
      dir_seen_q <= dir_seen_d;
    end
  end

endmodule

/* rtl/tmf_mix_pipe.sv */
// pipelined thruster mix: gain products, 0.81 weighting, q32 sums and clamp
// depends on tmf_pkg
module tmf_mix_pipe (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tmf_pkg::dev_t    dev_i,
  input  tmf_pkg::gains_t  gains_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tmf_pkg::pulses_t pulses_o
);
  import tmf_pkg::*;

  localparam logic signed [SumW-1:0] Base = {4'd0, NeutralPulse, 32'd0};

  // stage valids and ready chain
  logic v1_q, v2_q, v3_q, vo_q;
  logic r1, r2, r3, ro;

  assign ro = !vo_q || out_ready_i;
  assign r3 = !v3_q || ro;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o  = r1;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (ro) vo_q <= v3_q;
    end
  end

  // stage 1: deviations
  dev_t dev_q;
  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      dev_q <= dev_i;
    end
  end

  // stage 2: gain times deviation
  logic signed [ProdW-1:0] pf_d, pl_d, py_d, pg_d, pf_q, pl_q, py_q, pg_q;
  assign pf_d = ProdW'($signed({1'b0, gains_i.forward})) * ProdW'(dev_q.forward);
  assign pl_d = ProdW'($signed({1'b0, gains_i.lateral})) * ProdW'(dev_q.lateral);
  assign py_d = ProdW'($signed({1'b0, gains_i.yaw}))     * ProdW'(dev_q.yaw);
  assign pg_d = ProdW'($signed({1'b0, gains_i.gas}))     * ProdW'(dev_q.gas);

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      pf_q <= pf_d;
      pl_q <= pl_d;
      py_q <= py_d;
      pg_q <= pg_d;
    end
  end

  // stage 3: 0.81 weighting for thrusters 1 and 2
  logic signed [WProdW-1:0] yw_d, lw_d, yw_q, lw_q;
  logic signed [ProdW-1:0]  pf3_q, pl3_q, py3_q, pg3_q;
  assign yw_d = WProdW'(py_q) * WProdW'($signed({1'b0, WeightQ16}));
  assign lw_d = WProdW'(pl_q) * WProdW'($signed({1'b0, WeightQ16}));

  always_ff @(posedge clk_i) begin
    if (r3 && v2_q) begin
      yw_q  <= yw_d;
      lw_q  <= lw_d;
      pf3_q <= pf_q;
      pl3_q <= pl_q;
      py3_q <= py_q;
      pg3_q <= pg_q;
    end
  end

  // output stage: q32 sums and clamp
  logic signed [SumW-1:0] f_s, l_s, y_s, g_s, yw_s, lw_s;
  logic signed [SumW-1:0] m1_s, m2_s, m3_s, m4_s, m5_s;
  pulses_t pulses_d, pulses_q;

  assign f_s  = {{(SumW-ProdW-16){pf3_q[ProdW-1]}}, pf3_q, 16'd0};
  assign l_s  = {{(SumW-ProdW-16){pl3_q[ProdW-1]}}, pl3_q, 16'd0};
  assign y_s  = {{(SumW-ProdW-16){py3_q[ProdW-1]}}, py3_q, 16'd0};
  assign g_s  = {{(SumW-ProdW-16){pg3_q[ProdW-1]}}, pg3_q, 16'd0};
  assign yw_s = {{(SumW-WProdW){yw_q[WProdW-1]}}, yw_q};
  assign lw_s = {{(SumW-WProdW){lw_q[WProdW-1]}}, lw_q};

  assign m1_s = Base - f_s - yw_s - lw_s;
  assign m2_s = Base - f_s + yw_s + lw_s;
  assign m3_s = Base - f_s - y_s + l_s;
  assign m4_s = Base - f_s + y_s - l_s;
  assign m5_s = Base - g_s;

  always_comb begin
    pulses_d.m1 = to_pulse(m1_s);
    pulses_d.m2 = to_pulse(m2_s);
    pulses_d.m3 = to_pulse(m3_s);
    pulses_d.m4 = to_pulse(m4_s);
    pulses_d.m5 = to_pulse(m5_s);
    pulses_d.m6 = to_pulse(m5_s);
  end

  always_ff @(posedge clk_i) begin
    if (ro && v3_q) begin
      pulses_q <= pulses_d;
    end
  end

  assign pulses_o = pulses_q;

endmodule

/* rtl/thruster_mixer_failsafe_unit.sv */
// Six-thruster mixer with stick failsafe. Takes one beat per clock cycle unless
// the output stalls: throttle and direction updates are absorbed at once and
// give no result, a control tick gives one beat of six pulses after it passes
// the deviation register and the two chained multiplier stages (gain product,
// then the 0.81 weighting) ahead of the sum and output register. Stale-stick
// timeouts and held-stick updates take effect at the cycle a beat is taken, so
// the next beat always sees them. Configuration is a plain write port with no
// read-back and should be written only while no tick is in flight.
// depends on tmf_pkg, tmf_stick_hold, tmf_mix_pipe
module thruster_mixer_failsafe_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tmf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tmf_pkg::GainW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [tmf_pkg::StickW-1:0]    stick_forward_i,
  input  logic [tmf_pkg::StickW-1:0]    stick_lateral_i,
  input  logic [tmf_pkg::StickW-1:0]    stick_yaw_i,
  input  logic [tmf_pkg::StickW-1:0]    stick_gas_i,
  input  logic [tmf_pkg::TimeW-1:0]     time_now_i,
  input  logic                          auto_yaw_on_i,
  input  logic [tmf_pkg::StickW-1:0]    auto_yaw_value_i,
  input  logic                          auto_depth_on_i,
  input  logic [tmf_pkg::StickW-1:0]    auto_gas_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tmf_pkg::PulseW-1:0]    pulse_m1_o,
  output logic [tmf_pkg::PulseW-1:0]    pulse_m2_o,
  output logic [tmf_pkg::PulseW-1:0]    pulse_m3_o,
  output logic [tmf_pkg::PulseW-1:0]    pulse_m4_o,
  output logic [tmf_pkg::PulseW-1:0]    pulse_m5_o,
  output logic [tmf_pkg::PulseW-1:0]    pulse_m6_o
);
  import tmf_pkg::*;

  gains_t           gains_q;
  logic             motors_en_q;
  logic [GainW-1:0] stale_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.forward <= ForwardGainRst;
      gains_q.lateral <= LateralGainRst;
      gains_q.yaw     <= YawGainRst;
      gains_q.gas     <= GasGainRst;
      motors_en_q     <= 1'b1;
      stale_limit_q   <= StaleLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FORWARD_GAIN: gains_q.forward <= cfg_wdata_i;
        CFG_LATERAL_GAIN: gains_q.lateral <= cfg_wdata_i;
        CFG_YAW_GAIN:     gains_q.yaw     <= cfg_wdata_i;
        CFG_GAS_GAIN:     gains_q.gas     <= cfg_wdata_i;
        CFG_MOTORS_EN:    motors_en_q     <= cfg_wdata_i[0];
        CFG_STALE_LIMIT:  stale_limit_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  logic    accept;
  logic    tick;
  dev_t    dev;
  pulses_t pulses;

  assign accept = in_valid_i && in_ready_o;

  tmf_stick_hold u_hold (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .stick_forward_i  (stick_forward_i),
    .stick_lateral_i  (stick_lateral_i),
    .stick_yaw_i      (stick_yaw_i),
    .stick_gas_i      (stick_gas_i),
    .time_now_i       (time_now_i),
    .auto_yaw_on_i    (auto_yaw_on_i),
    .auto_yaw_value_i (auto_yaw_value_i),
    .auto_depth_on_i  (auto_depth_on_i),
    .auto_gas_value_i (auto_gas_value_i),
    .motors_enabled_i (motors_en_q),
    .stale_limit_i    (stale_limit_q),
    .tick_o           (tick),
    .dev_o            (dev)
  );

  tmf_mix_pipe u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i && tick),
    .in_ready_o  (in_ready_o),
    .dev_i       (dev),
    .gains_i     (gains_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pulses_o    (pulses)
  );

  assign pulse_m1_o = pulses.m1;
  assign pulse_m2_o = pulses.m2;
  assign pulse_m3_o = pulses.m3;
  assign pulse_m4_o = pulses.m4;
  assign pulse_m5_o = pulses.m5;
  assign pulse_m6_o = pulses.m6;

endmodule

/* test/tmf_pulse_checker.sv */
// pulse checker for the thruster mixer: follows config writes and input beats,
// predicts the six pulses of every control tick and compares them with the output beats
// depends on tmf_pkg
module tmf_pulse_checker
  import tmf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [GainW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          mode_i,
  input  logic [StickW-1:0]   stick_forward_i,
  input  logic [StickW-1:0]   stick_lateral_i,
  input  logic [StickW-1:0]   stick_yaw_i,
  input  logic [StickW-1:0]   stick_gas_i,
  input  logic [TimeW-1:0]    time_now_i,
  input  logic                auto_yaw_on_i,
  input  logic [StickW-1:0]   auto_yaw_value_i,
  input  logic                auto_depth_on_i,
  input  logic [StickW-1:0]   auto_gas_value_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [PulseW-1:0]   pulse_m1_i,
  input  logic [PulseW-1:0]   pulse_m2_i,
  input  logic [PulseW-1:0]   pulse_m3_i,
  input  logic [PulseW-1:0]   pulse_m4_i,
  input  logic [PulseW-1:0]   pulse_m5_i,
  input  logic [PulseW-1:0]   pulse_m6_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  gains_t            gain_q16;
  logic              motors_on;
  logic [GainW-1:0]  stale_limit;
  logic [StickW-1:0] held_forward, held_lateral, held_yaw, held_gas;
  logic [TimeW-1:0]  throttle_at, direction_at;
  pulses_t           pulses_due[$];
  int unsigned       fails;

  function automatic longint offset_from_center(input logic [StickW-1:0] stick);
    longint s, c;
    s = longint'(stick);
    c = longint'(NeutralStick);
    return c - s;
  endfunction

  function automatic logic [PulseW-1:0] clip_pulse(input longint q32);
    longint ceiling;
    ceiling = longint'(MaxPulse);
    ceiling = ceiling <<< 32;
    if (q32 < 0) return '0;
    if (q32 > ceiling) return MaxPulse;
    return q32[43:32];
  endfunction

  function automatic pulses_t mix_pulses(input logic [StickW-1:0] fwd, lat, yaw, gas);
    longint base, df, dl, dy, dg, gf, gl, gy, gg, wt;
    longint f, y, l, yw, lw, g;
    pulses_t p;
    base = longint'(NeutralPulse);
    base = base <<< 32;
    df = offset_from_center(fwd);
    dl = offset_from_center(lat);
    dy = offset_from_center(yaw);
    dg = offset_from_center(gas);
    gf = longint'(gain_q16.forward);
    gl = longint'(gain_q16.lateral);
    gy = longint'(gain_q16.yaw);
    gg = longint'(gain_q16.gas);
    wt = longint'(WeightQ16);
    f  = gf * df * 65536;
    y  = gy * dy * 65536;
    l  = gl * dl * 65536;
    yw = gy * dy * wt;
    lw = gl * dl * wt;
    g  = gg * dg * 65536;
    p.m1 = clip_pulse(base - f - yw - lw);
    p.m2 = clip_pulse(base - f + yw + lw);
    p.m3 = clip_pulse(base - f - y + l);
    p.m4 = clip_pulse(base - f + y - l);
    p.m5 = clip_pulse(base - g);
    p.m6 = clip_pulse(base - g);
    return p;
  endfunction

  task automatic check_pulse(input string name, input logic [PulseW-1:0] want,
                             input logic [PulseW-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fails++;
    end
  endtask

  task automatic take_input_beat();
    pulses_t p;
    case (mode_i)
      MODE_THROTTLE: begin
        held_gas    = stick_gas_i;
        throttle_at = time_now_i;
      end
      MODE_DIRECTION: begin
        held_forward = stick_forward_i;
        held_lateral = stick_lateral_i;
        held_yaw     = stick_yaw_i;
        direction_at = time_now_i;
      end
      MODE_TICK: begin
        if (!motors_on) begin
          p = {6{NeutralPulse}};
          pulses_due.push_back(p);
        end else begin
          p = mix_pulses(held_forward, held_lateral,
                         auto_yaw_on_i ? auto_yaw_value_i : held_yaw,
                         auto_depth_on_i ? auto_gas_value_i : held_gas);
          pulses_due.push_back(p);
          // stale groups fall back to neutral after the mix
          if (TimeW'(time_now_i - throttle_at) >= {{(TimeW-GainW){1'b0}}, stale_limit})
            held_gas = NeutralStick;
          if (TimeW'(time_now_i - direction_at) >= {{(TimeW-GainW){1'b0}}, stale_limit})
          begin
            held_forward = NeutralStick;
            held_lateral = NeutralStick;
            held_yaw     = NeutralStick;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pulses_t want;
    if (!rst_ni) begin
      gain_q16     = '{forward: ForwardGainRst, lateral: LateralGainRst,
                       yaw: YawGainRst, gas: GasGainRst};
      motors_on    = 1'b1;
      stale_limit  = StaleLimitRst;
      held_forward = NeutralStick;
      held_lateral = NeutralStick;
      held_yaw     = NeutralStick;
      held_gas     = NeutralStick;
      throttle_at  = '0;
      direction_at = '0;
      pulses_due.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FORWARD_GAIN: gain_q16.forward = cfg_wdata_i;
          CFG_LATERAL_GAIN: gain_q16.lateral = cfg_wdata_i;
          CFG_YAW_GAIN:     gain_q16.yaw     = cfg_wdata_i;
          CFG_GAS_GAIN:     gain_q16.gas     = cfg_wdata_i;
          CFG_MOTORS_EN:    motors_on        = cfg_wdata_i[0];
          CFG_STALE_LIMIT:  stale_limit      = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pulses_due.size() == 0) begin
          $error("pulse beat with no tick waiting");
          fails++;
        end else begin
          want = pulses_due.pop_front();
          check_pulse("pulse_m1", want.m1, pulse_m1_i);
          check_pulse("pulse_m2", want.m2, pulse_m2_i);
          check_pulse("pulse_m3", want.m3, pulse_m3_i);
          check_pulse("pulse_m4", want.m4, pulse_m4_i);
          check_pulse("pulse_m5", want.m5, pulse_m5_i);
          check_pulse("pulse_m6", want.m6, pulse_m6_i);
        end
      end
      if (in_valid_i && in_ready_i) take_input_beat();
      fail_count_o <= fails;
      pending_o    <= pulses_due.size();
    end
  end

endmodule

/* test/testbench.sv */
// top of the thruster mixer test: drives stick updates, ticks and config writes
// into thruster_mixer_failsafe_unit and gives the verdict from tmf_pulse_checker
// depends on tmf_pkg, thruster_mixer_failsafe_unit, tmf_pulse_checker
module testbench;
  import tmf_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainWait = 8;

  typedef struct {
    logic [1:0]        mode;
    logic [StickW-1:0] fwd, lat, yaw, gas;
    logic [TimeW-1:0]  now;
    logic              ayaw_on;
    logic [StickW-1:0] ayaw;
    logic              adepth_on;
    logic [StickW-1:0] agas;
  } stim_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GainW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i = '0;
  logic [StickW-1:0]  stick_forward_i = '0;
  logic [StickW-1:0]  stick_lateral_i = '0;
  logic [StickW-1:0]  stick_yaw_i = '0;
  logic [StickW-1:0]  stick_gas_i = '0;
  logic [TimeW-1:0]   time_now_i = '0;
  logic               auto_yaw_on_i = 1'b0;
  logic [StickW-1:0]  auto_yaw_value_i = '0;
  logic               auto_depth_on_i = 1'b0;
  logic [StickW-1:0]  auto_gas_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [PulseW-1:0]  pulse_m1_o, pulse_m2_o, pulse_m3_o;
  logic [PulseW-1:0]  pulse_m4_o, pulse_m5_o, pulse_m6_o;
  int unsigned        fail_count, pending;

  int unsigned        send_idle_pct = 0;
  int unsigned        recv_idle_pct = 0;
  bit                 hold_req = 1'b0;
  logic [TimeW-1:0]   clock_ms = '0;
  int unsigned        cycles = 0;

  thruster_mixer_failsafe_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i,
    .stick_forward_i, .stick_lateral_i, .stick_yaw_i, .stick_gas_i, .time_now_i,
    .auto_yaw_on_i, .auto_yaw_value_i, .auto_depth_on_i, .auto_gas_value_i,
    .out_valid_o, .out_ready_i,
    .pulse_m1_o, .pulse_m2_o, .pulse_m3_o, .pulse_m4_o, .pulse_m5_o, .pulse_m6_o
  );

  tmf_pulse_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i,
    .stick_forward_i, .stick_lateral_i, .stick_yaw_i, .stick_gas_i, .time_now_i,
    .auto_yaw_on_i, .auto_yaw_value_i, .auto_depth_on_i, .auto_gas_value_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pulse_m1_i(pulse_m1_o), .pulse_m2_i(pulse_m2_o), .pulse_m3_i(pulse_m3_o),
    .pulse_m4_i(pulse_m4_o), .pulse_m5_i(pulse_m5_o), .pulse_m6_i(pulse_m6_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off on request
  initial begin
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        for (held = 0; held < LongHold; held++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic stim_t directed_beat(input logic [1:0] mode,
                                          input logic [StickW-1:0] fwd, lat, yaw, gas,
                                          input logic [TimeW-1:0] now,
                                          input logic ayaw_on, input logic [StickW-1:0] ayaw,
                                          input logic adepth_on, input logic [StickW-1:0] agas);
    stim_t s;
    s = '{mode, fwd, lat, yaw, gas, now, ayaw_on, ayaw, adepth_on, agas};
    return s;
  endfunction

  function automatic logic [StickW-1:0] random_stick();
    if ($urandom_range(99) < 8) return StickW'($urandom_range(1023, 1001));
    return StickW'($urandom_range(1000));
  endfunction

  task automatic make_random_beat(output stim_t s);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35) s.mode = MODE_THROTTLE;
    else if (pick < 70) s.mode = MODE_DIRECTION;
    else if (pick < 95) s.mode = MODE_TICK;
    else s.mode = ModeUnused;
    pick = $urandom_range(99);
    if (pick < 2) clock_ms = $urandom;
    else if (pick < 8) clock_ms += $urandom_range(600, 200);
    else clock_ms += $urandom_range(30);
    s.now       = clock_ms;
    s.fwd       = random_stick();
    s.lat       = random_stick();
    s.yaw       = random_stick();
    s.gas       = random_stick();
    s.ayaw_on   = ($urandom_range(99) < 30);
    s.ayaw      = random_stick();
    s.adepth_on = ($urandom_range(99) < 30);
    s.agas      = random_stick();
  endtask

  task automatic offer(input stim_t s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= s.mode;
    stick_forward_i  <= s.fwd;
    stick_lateral_i  <= s.lat;
    stick_yaw_i      <= s.yaw;
    stick_gas_i      <= s.gas;
    time_now_i       <= s.now;
    auto_yaw_on_i    <= s.ayaw_on;
    auto_yaw_value_i <= s.ayaw;
    auto_depth_on_i  <= s.adepth_on;
    auto_gas_value_i <= s.agas;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [GainW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic load_setting(input logic [GainW-1:0] fg, lg, yg, gg,
                              input logic en, input logic [GainW-1:0] stale);
    drain();
    write_reg(CFG_FORWARD_GAIN, fg);
    write_reg(CFG_LATERAL_GAIN, lg);
    write_reg(CFG_YAW_GAIN, yg);
    write_reg(CFG_GAS_GAIN, gg);
    write_reg(CFG_MOTORS_EN, {{(GainW-1){1'b0}}, en});
    write_reg(CFG_STALE_LIMIT, stale);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    stim_t s;
    repeat (count) begin
      make_random_beat(s);
      offer(s);
    end
  endtask

  function automatic logic [GainW-1:0] random_gain();
    return GainW'($urandom_range(65535));
  endfunction

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: neutral start, extremes, stale boundary, wrap, unused mode
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd0, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_DIRECTION, 0, 1023, 1000, 0, 32'd10, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_THROTTLE, 0, 0, 0, 1023, 32'd10, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_TICK, 1023, 1023, 1023, 1023, 32'd259, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd260, 1'b1, 0, 1'b1, 1023));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd261, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(ModeUnused, 1023, 0, 1023, 0, 32'hFFFF_FFFF, 1'b1, 1023, 1'b1, 1023));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd262, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_DIRECTION, 1023, 0, 0, 1000, 32'hFFFF_FFF0, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_THROTTLE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd5, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd100, 1'b1, 1023, 1'b1, 0));
    offer(directed_beat(MODE_DIRECTION, 1000, 1000, 1000, 0, 32'd200, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_THROTTLE, 0, 0, 0, 1000, 32'd200, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd200, 1'b1, 1000, 1'b1, 1000));
    offer(directed_beat(MODE_DIRECTION, 0, 0, 0, 0, 32'd300, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_THROTTLE, 0, 0, 0, 0, 32'd300, 1'b0, 0, 1'b0, 0));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd549, 1'b0, 500, 1'b0, 500));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd550, 1'b1, 500, 1'b1, 500));
    offer(directed_beat(MODE_TICK, 0, 0, 0, 0, 32'd551, 1'b0, 0, 1'b0, 0));
    clock_ms = 32'd600;

    send_idle_pct = 9;
    recv_idle_pct = 84;
    load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'd250);
    run_random(125);
    load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0);
    run_random(125);

    send_idle_pct = 84;
    recv_idle_pct = 9;
    load_setting(random_gain(), random_gain(), random_gain(), random_gain(), 1'b0,
                 16'hFFFF);
    run_random(125);
    load_setting(random_gain(), random_gain(), random_gain(), random_gain(), 1'b1,
                 GainW'($urandom_range(300, 20)));
    run_random(125);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_setting(random_gain(), random_gain(), random_gain(), random_gain(), 1'b1,
                 16'hFFFF);
    hold_req = 1'b1;
    run_random(125);
    load_setting(ForwardGainRst, LateralGainRst, YawGainRst, GasGainRst, 1'b1,
                 StaleLimitRst);
    run_random(125);

    drain();
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

/* thruster_mixer_failsafe_unit.f */
rtl/tmf_pkg.sv
rtl/tmf_stick_hold.sv
rtl/tmf_mix_pipe.sv
rtl/thruster_mixer_failsafe_unit.sv
test/tmf_pulse_checker.sv
test/testbench.sv
